[rtl/rpb_pkg.sv]
// ----------------------------------------------------------------------------
// rpb_pkg: shared types and constants
// Item types, fixed-point constants and the CORDIC arctangent table for the
// relative position rotate and bearing block.
// ----------------------------------------------------------------------------
package rpb_pkg;

	// width of the rotation datapath and of both angle accumulators
	localparam int ROT_W = 20;
	localparam int Z_W   = 20;

	// fixed-point constants, 16 fractional bits
	localparam int unsigned GAIN_Q16 = 39797;
	localparam int unsigned PI_Q16   = 205887;

	// reciprocals scaled by 2^40 for constant division
	localparam int RECIP_SHIFT = 40;
	localparam logic [29:0] RECIP_1800 = 30'((64'd1 << RECIP_SHIFT) / 64'd1800);
	localparam logic [22:0] RECIP_PI   = 23'((64'd1 << RECIP_SHIFT) / 64'd205887);

	// register indexes
	localparam logic REG_OFFSET_ENABLE = 1'b0;
	localparam logic REG_CROSS_X_OFFSET = 1'b1;

	typedef struct packed {
		logic signed [31:0] boat_lon;
		logic signed [31:0] boat_lat;
		logic signed [31:0] ref_lon;
		logic signed [31:0] ref_lat;
		logic [11:0]        heading_tenths;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] x_cross;
		logic signed [31:0] y_cross;
		logic [8:0]         bearing_deg;
	} out_item_t;

	// round(atan(2^-i) * 2^16)
	function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			0: v = 20'sd51472;
			1: v = 20'sd30386;
			2: v = 20'sd16055;
			3: v = 20'sd8150;
			4: v = 20'sd4091;
			5: v = 20'sd2047;
			6: v = 20'sd1024;
			7: v = 20'sd512;
			8: v = 20'sd256;
			9: v = 20'sd128;
			10: v = 20'sd64;
			11: v = 20'sd32;
			12: v = 20'sd16;
			13: v = 20'sd8;
			14: v = 20'sd4;
			15: v = 20'sd2;
			16: v = 20'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/rpb_rot_cell.sv]
// ----------------------------------------------------------------------------
// rpb_rot_cell: one CORDIC rotation step
// Turns (x, y) toward the residual angle z by atan(2^-STAGE) and hands the
// result and a side tag to the next cell.
// ----------------------------------------------------------------------------
module rpb_rot_cell #(
	parameter int STAGE = 0,
	parameter int TAG_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_i,
	input  logic signed [rpb_pkg::ROT_W-1:0] x_i,
	input  logic signed [rpb_pkg::ROT_W-1:0] y_i,
	input  logic signed [rpb_pkg::Z_W-1:0]   z_i,
	input  logic [TAG_W-1:0]               tag_i,
	output logic                           v_q,
	output logic signed [rpb_pkg::ROT_W-1:0] x_q,
	output logic signed [rpb_pkg::ROT_W-1:0] y_q,
	output logic signed [rpb_pkg::Z_W-1:0]   z_q,
	output logic [TAG_W-1:0]               tag_q
);
	import rpb_pkg::*;

	localparam logic signed [Z_W-1:0] ANG = atan_entry(STAGE);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	// rotation step, direction from the sign of z
	always_ff @(posedge clk) begin
		if (z_i >= 0) begin
			x_q <= x_i - (y_i >>> STAGE);
			y_q <= y_i + (x_i >>> STAGE);
			z_q <= z_i - ANG;
		end else begin
			x_q <= x_i + (y_i >>> STAGE);
			y_q <= y_i - (x_i >>> STAGE);
			z_q <= z_i + ANG;
		end
		tag_q <= tag_i;
	end

endmodule

[rtl/rpb_vec_cell.sv]
// ----------------------------------------------------------------------------
// rpb_vec_cell: one CORDIC vectoring step
// Drives y toward zero by atan(2^-STAGE) and sums the angle turned so far.
// ----------------------------------------------------------------------------
module rpb_vec_cell #(
	parameter int STAGE = 0,
	parameter int VW    = 34,
	parameter int TAG_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         v_i,
	input  logic signed [VW-1:0]         x_i,
	input  logic signed [VW-1:0]         y_i,
	input  logic signed [rpb_pkg::Z_W-1:0] z_i,
	input  logic [TAG_W-1:0]             tag_i,
	output logic                         v_q,
	output logic signed [VW-1:0]         x_q,
	output logic signed [VW-1:0]         y_q,
	output logic signed [rpb_pkg::Z_W-1:0] z_q,
	output logic [TAG_W-1:0]             tag_q
);
	import rpb_pkg::*;

	localparam logic signed [Z_W-1:0] ANG = atan_entry(STAGE);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	// vectoring step, direction from the sign of y
	always_ff @(posedge clk) begin
		if (y_i > 0) begin
			x_q <= x_i + (y_i >>> STAGE);
			y_q <= y_i - (x_i >>> STAGE);
			z_q <= z_i + ANG;
		end else begin
			x_q <= x_i - (y_i >>> STAGE);
			y_q <= y_i + (x_i >>> STAGE);
			z_q <= z_i - ANG;
		end
		tag_q <= tag_i;
	end

endmodule

[rtl/relative_position_rotate_and_bearing_top.sv]
// ----------------------------------------------------------------------------
// relative_position_rotate_and_bearing_top: rotate offset and find bearing
// Rotates a boat's offset from a ship into the ship's frame and reports the
// whole-degree bearing of the rotated vector.
// ----------------------------------------------------------------------------
// Usage:
//   A transfer is taken when start is high and busy is low. busy stays low:
//   the block takes a new item every cycle.
//   Each result is shown on result for one cycle with done high; the receiver
//   cannot stall, so results are never held back.
//   One row of rotation cells builds cosine and sine, a second row of
//   vectoring cells the arctangent; each cell is one pipeline stage, so
//   throughput is one item per cycle.
//   Configuration goes through the APB port: offset_enable at byte 0,
//   cross_x_offset at byte 4; write only while no item is in flight.
//   Reset clears the registers and all valid flags; items in flight are lost.
// ----------------------------------------------------------------------------
module relative_position_rotate_and_bearing_top #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rpb_pkg::in_item_t  cmd,
	output logic               done,
	output rpb_pkg::out_item_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rpb_pkg::*;

	localparam int XW    = COORD_WIDTH;
	localparam int N     = CORDIC_STAGES;
	localparam int VW    = XW + 2;
	localparam int DW    = 33;
	localparam int PW    = ROT_W + DW;
	localparam int SUM_W = PW + 1;
	localparam int OW    = (XW > 32 ? XW : 32) + 1;
	localparam int RT_W  = 2 + 2 * DW;
	localparam int VT_W  = 2 * XW;
	localparam int LAT   = 11 + 2 * N;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'sd1 <<< (XW - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam logic signed [OW-1:0] OSAT_HI = OW'(SAT_HI);
	localparam logic signed [OW-1:0] OSAT_LO = OW'(SAT_LO);

	// configuration registers
	logic               offset_enable_q;
	logic signed [31:0] cross_x_offset_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_enable_q  <= 1'b0;
			cross_x_offset_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_OFFSET_ENABLE:  offset_enable_q  <= pwdata[0];
				REG_CROSS_X_OFFSET: cross_x_offset_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_OFFSET_ENABLE:  prdata = {31'b0, offset_enable_q};
			REG_CROSS_X_OFFSET: prdata = cross_x_offset_q;
		endcase
	end

	// stage 1: differences, heading wrap and quadrant split
	logic [11:0] h_w;
	logic [1:0]  q_c;
	logic [11:0] r_c;
	logic               v_s1;
	logic [9:0]         r_s1;
	logic [1:0]         q_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;

	always_comb begin
		h_w = (cmd.heading_tenths >= 12'd3600) ? cmd.heading_tenths - 12'd3600
			: cmd.heading_tenths;
		priority if (h_w >= 12'd2700) begin
			q_c = 2'd3; r_c = h_w - 12'd2700;
		end else if (h_w >= 12'd1800) begin
			q_c = 2'd2; r_c = h_w - 12'd1800;
		end else if (h_w >= 12'd900) begin
			q_c = 2'd1; r_c = h_w - 12'd900;
		end else begin
			q_c = 2'd0; r_c = h_w;
		end
	end

	always_ff @(posedge clk) begin
		r_s1  <= r_c[9:0];
		q_s1  <= q_c;
		dx_s1 <= DW'(cmd.boat_lon) - DW'(cmd.ref_lon);
		dy_s1 <= DW'(cmd.boat_lat) - DW'(cmd.ref_lat);
	end

	// stage 2: scale rest angle to radians numerator
	logic                v_s2;
	logic [27:0]         n_s2;
	logic [RT_W-1:0]     tag_s2;
	always_ff @(posedge clk) begin
		n_s2   <= 28'(28'(r_s1) * 28'(PI_Q16) + 28'd900);
		tag_s2 <= {q_s1, dx_s1, dy_s1};
	end

	// stage 3: reciprocal multiply for the divide by 1800
	logic            v_s3;
	logic [27:0]     n_s3;
	logic [57:0]     p_s3;
	logic [RT_W-1:0] tag_s3;
	always_ff @(posedge clk) begin
		p_s3   <= 58'(n_s2) * 58'(RECIP_1800);
		n_s3   <= n_s2;
		tag_s3 <= tag_s2;
	end

	// stage 4: quotient correction gives the base angle
	logic [17:0]     qa_c;
	logic [27:0]     rem_c;
	logic            v_s4;
	logic signed [Z_W-1:0] z0_s4;
	logic [RT_W-1:0] tag_s4;
	always_comb begin
		qa_c  = p_s3[57:RECIP_SHIFT];
		rem_c = n_s3 - 28'(28'(qa_c) * 28'd1800);
	end
	always_ff @(posedge clk) begin
		z0_s4  <= (rem_c >= 28'd1800) ? Z_W'(qa_c + 18'd1) : Z_W'(qa_c);
		tag_s4 <= tag_s3;
	end

	// valid flags of the front and back stages
	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [N:0] rv, vv;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= rv[N]; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= vv[N]; v_s10 <= v_s9; done <= v_s10;
		end
	end

	// row of rotation cells: cosine and sine of the base angle
	logic signed [ROT_W-1:0] rx [N+1];
	logic signed [ROT_W-1:0] ry [N+1];
	logic signed [Z_W-1:0]   rz [N+1];
	logic [RT_W-1:0]         rt [N+1];
	assign rv[0] = v_s4;
	assign rx[0] = ROT_W'(GAIN_Q16);
	assign ry[0] = '0;
	assign rz[0] = z0_s4;
	assign rt[0] = tag_s4;

	for (genvar i = 0; i < N; i++) begin : g_rot
		rpb_rot_cell #(.STAGE(i), .TAG_W(RT_W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(rv[i]), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]), .tag_i(rt[i]),
			.v_q(rv[i+1]), .x_q(rx[i+1]), .y_q(ry[i+1]), .z_q(rz[i+1]),
			.tag_q(rt[i+1])
		);
	end

	// stage 5: quadrant map and the four products
	logic [1:0]              q_r;
	logic signed [DW-1:0]    dx_r, dy_r;
	logic signed [ROT_W-1:0] c_c, s_c;
	logic signed [PW-1:0]    pcx_s5, psy_s5, psx_s5, pcy_s5;
	always_comb begin
		{q_r, dx_r, dy_r} = rt[N];
		unique case (q_r)
			2'd0: begin c_c = rx[N];  s_c = ry[N];  end
			2'd1: begin c_c = -ry[N]; s_c = rx[N];  end
			2'd2: begin c_c = -rx[N]; s_c = -ry[N]; end
			2'd3: begin c_c = ry[N];  s_c = -rx[N]; end
		endcase
	end
	always_ff @(posedge clk) begin
		pcx_s5 <= PW'(c_c) * PW'(dx_r);
		psy_s5 <= PW'(s_c) * PW'(dy_r);
		psx_s5 <= PW'(s_c) * PW'(dx_r);
		pcy_s5 <= PW'(c_c) * PW'(dy_r);
	end

	// stage 6: rotated sums
	logic signed [SUM_W-1:0] sx_s6, sy_s6;
	always_ff @(posedge clk) begin
		sx_s6 <= SUM_W'(pcx_s5) - SUM_W'(psy_s5);
		sy_s6 <= SUM_W'(psx_s5) + SUM_W'(pcy_s5);
	end

	// stage 7: truncate toward zero and saturate
	function automatic logic signed [XW-1:0] trunc_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] t;
		t = (v < 0) ? ((v + SUM_W'(65535)) >>> 16) : (v >>> 16);
		if (t > SAT_HI) return XW'(SAT_HI);
		if (t < SAT_LO) return XW'(SAT_LO);
		return XW'(t);
	endfunction

	logic signed [XW-1:0] x_s7, y_s7;
	always_ff @(posedge clk) begin
		x_s7 <= trunc_sat(sx_s6);
		y_s7 <= trunc_sat(sy_s6);
	end

	// stage 8: optional x offset with second saturation
	logic signed [OW-1:0] xo_c;
	logic signed [XW-1:0] xf_c;
	logic signed [XW-1:0] x_s8, y_s8;
	always_comb begin
		xo_c = OW'(x_s7) + OW'(cross_x_offset_q);
		priority if (!offset_enable_q) xf_c = x_s7;
		else if (xo_c > OSAT_HI)       xf_c = XW'(OSAT_HI);
		else if (xo_c < OSAT_LO)       xf_c = XW'(OSAT_LO);
		else                           xf_c = XW'(xo_c);
	end
	always_ff @(posedge clk) begin
		x_s8 <= xf_c;
		y_s8 <= y_s7;
	end

	// row of vectoring cells on the magnitudes
	logic signed [VW-1:0]  vx [N+1];
	logic signed [VW-1:0]  vy [N+1];
	logic signed [Z_W-1:0] vz [N+1];
	logic [VT_W-1:0]       vt [N+1];
	assign vv[0] = v_s8;
	assign vx[0] = (x_s8 < 0) ? -VW'(x_s8) : VW'(x_s8);
	assign vy[0] = (y_s8 < 0) ? -VW'(y_s8) : VW'(y_s8);
	assign vz[0] = '0;
	assign vt[0] = {x_s8, y_s8};

	for (genvar i = 0; i < N; i++) begin : g_vec
		rpb_vec_cell #(.STAGE(i), .VW(VW), .TAG_W(VT_W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(vv[i]), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]), .tag_i(vt[i]),
			.v_q(vv[i+1]), .x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1]),
			.tag_q(vt[i+1])
		);
	end

	// stage 9: clamp angle at zero and scale to degrees numerator
	logic [26:0]       t_s9;
	logic [VT_W-1:0]   xy_s9;
	always_ff @(posedge clk) begin
		t_s9  <= (vz[N] < 0) ? '0 : 27'(27'(vz[N][Z_W-2:0]) * 27'd180);
		xy_s9 <= vt[N];
	end

	// stage 10: reciprocal multiply for the divide by pi
	logic [49:0]     p_s10;
	logic [26:0]     t_s10;
	logic [VT_W-1:0] xy_s10;
	always_ff @(posedge clk) begin
		p_s10  <= 50'(t_s9) * 50'(RECIP_PI);
		t_s10  <= t_s9;
		xy_s10 <= xy_s9;
	end

	// stage 11: quotient correction, quadrant rules and result register
	logic [9:0]           qd_c;
	logic [27:0]          rd_c;
	logic [9:0]           d_c;
	logic [8:0]           a_c;
	logic [9:0]           b_c;
	logic signed [XW-1:0] xr_c, yr_c;
	logic signed [XW-1:0] x_s11, y_s11;
	always_comb begin
		{xr_c, yr_c} = xy_s10;
		qd_c = p_s10[49:RECIP_SHIFT];
		rd_c = 28'(t_s10) - 28'(28'(qd_c) * 28'(PI_Q16));
		d_c  = (rd_c >= 28'(PI_Q16)) ? qd_c + 10'd1 : qd_c;
		a_c  = (d_c > 10'd90) ? 9'd90 : d_c[8:0];
		if (yr_c == 0) a_c = 9'd0;
		priority if (xr_c > 0) begin
			b_c = (yr_c >= 0) ? 10'd90 - 10'(a_c) : 10'd90 + 10'(a_c);
		end else if (xr_c < 0) begin
			b_c = (yr_c <= 0) ? 10'd270 - 10'(a_c) : 10'd270 + 10'(a_c);
		end else begin
			b_c = (yr_c >= 0) ? 10'd0 : 10'd180;
		end
		if (b_c >= 10'd360) b_c = b_c - 10'd360;
	end
	always_ff @(posedge clk) begin
		result.x_cross     <= 32'(xr_c);
		result.y_cross     <= 32'(yr_c);
		result.bearing_deg <= b_c[8:0];
		x_s11              <= xr_c;
		y_s11              <= yr_c;
	end

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after fixed latency");
	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.bearing_deg < 9'd360))
		else $error("bearing out of range");
	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(done && x_s11 == 0 && y_s11 == 0) |-> (result.bearing_deg == 9'd0))
		else $error("zero vector must give bearing zero");
	a_east_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(done && x_s11 > 0 && y_s11 == 0) |-> (result.bearing_deg == 9'd90))
		else $error("positive x axis must give bearing ninety");

endmodule
